// ===== hw/rtl/restricted_ring_deque_unit_defines.svh =====
// ----------------------------------------------------------------------------
// restricted ring deque assertion macros
// concurrent check wrappers used by the file that asserts
// ----------------------------------------------------------------------------
`ifndef RESTRICTED_RING_DEQUE_UNIT_DEFINES_SVH
`define RESTRICTED_RING_DEQUE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define RRD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RRD_ASSERT(lbl, prop, msg)
`define RRD_ASSERT_IMPL(lbl, ante, cons, msg)
`define RRD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/rrd_pkg.sv =====
// ----------------------------------------------------------------------------
// rrd_pkg
// types and codes of the restricted ring deque
// ----------------------------------------------------------------------------
package rrd_pkg;

    localparam int IDX_W   = 5;
    localparam int VAL_W   = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW    = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_ALLOWED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 1'd1;

    localparam logic MODE_IN_RESTRICT  = 1'b0;
    localparam logic MODE_OUT_RESTRICT = 1'b1;

    localparam logic [CFG_DAT_W-1:0] CAPACITY_RESET = 5'd16;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [IDX_W-1:0] pos;
        logic [VAL_W-1:0] wdata;
    } t_mem_req;

endpackage

// ===== hw/rtl/rrd_if.sv =====
// ----------------------------------------------------------------------------
// rrd channel interfaces
// command, result and configuration channels with valid and ready
// ----------------------------------------------------------------------------
interface rrd_cmd_if;
    logic                                valid;
    logic                                ready;
    logic        [rrd_pkg::CMD_W-1:0]    command;
    logic signed [rrd_pkg::VAL_W-1:0]    push_value;

    modport source (output valid, command, push_value, input ready);
    modport sink   (input valid, command, push_value, output ready);
endinterface

interface rrd_res_if;
    logic                                valid;
    logic                                ready;
    logic        [rrd_pkg::STAT_W-1:0]   status;
    logic signed [rrd_pkg::VAL_W-1:0]    popped_value;

    modport source (output valid, status, popped_value, input ready);
    modport sink   (input valid, status, popped_value, output ready);
endinterface

interface rrd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rrd_pkg::CFG_IDX_W-1:0]       index;
    logic [rrd_pkg::CFG_DAT_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rrd_slot_ram.sv =====
// ----------------------------------------------------------------------------
// rrd_slot_ram
// single port slot memory, registered read
// ----------------------------------------------------------------------------
module rrd_slot_ram #(
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  rrd_pkg::t_mem_req           i_req,
    output logic [rrd_pkg::VAL_W-1:0]   o_rdata
);
    import rrd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [AW-1:0]    addr;
    logic [VAL_W-1:0] r_rdata;

    // ring positions start at one
    assign addr    = AW'(i_req.pos - IDX_W'(1));
    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= mem[addr];
        end
    end

endmodule

// ===== hw/rtl/rrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrd_ctrl
// front and rear indices, mode registers and per-command decision
// ----------------------------------------------------------------------------
module rrd_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  logic [rrd_pkg::CMD_W-1:0]      i_command,
    input  logic [rrd_pkg::VAL_W-1:0]      i_push_value,
    input  logic                           i_cfg_we,
    input  logic [rrd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rrd_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    output rrd_pkg::t_mem_req              o_req,
    output logic [rrd_pkg::STAT_W-1:0]     o_status,
    output logic                           o_pop_ok
);
    import rrd_pkg::*;

    logic [IDX_W-1:0]     r_front, n_front;
    logic [IDX_W-1:0]     r_rear, n_rear;
    logic [CFG_DAT_W-1:0] r_capacity;
    logic                 r_mode;
    logic [IDX_W-1:0]     ring_n;
    logic                 empty;
    logic                 full;
    logic                 not_allowed;
    t_mem_req             req;

    function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] p,
                                             input logic [IDX_W-1:0] n);
        return (p == n) ? IDX_W'(1) : p + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] prv(input logic [IDX_W-1:0] p,
                                             input logic [IDX_W-1:0] n);
        return (p == IDX_W'(1)) ? n : p - IDX_W'(1);
    endfunction

    always_comb begin
        if (r_capacity == '0) begin
            ring_n = IDX_W'(1);
        end else if (int'(r_capacity) > DEPTH) begin
            ring_n = IDX_W'(DEPTH);
        end else begin
            ring_n = IDX_W'(r_capacity);
        end
    end

    assign empty       = (r_front == '0) || (r_rear == '0);
    assign full        = !empty && (r_front == nxt(r_rear, ring_n));
    assign not_allowed = (i_command == CMD_PUSH_FRONT && r_mode == MODE_IN_RESTRICT) ||
                         (i_command == CMD_POP_REAR && r_mode == MODE_OUT_RESTRICT);

    always_comb begin
        n_front   = r_front;
        n_rear    = r_rear;
        o_status  = ST_OK;
        o_pop_ok  = 1'b0;
        req       = '0;
        req.wdata = i_push_value;
        if (not_allowed) begin
            o_status = ST_NOT_ALLOWED;
        end else if (i_command inside {CMD_PUSH_REAR, CMD_PUSH_FRONT}) begin
            if (empty) begin
                n_front   = IDX_W'(1);
                n_rear    = IDX_W'(1);
                req.wr_en = 1'b1;
                req.pos   = IDX_W'(1);
            end else if (full) begin
                o_status = ST_OVERFLOW;
            end else if (i_command == CMD_PUSH_REAR) begin
                n_rear    = nxt(r_rear, ring_n);
                req.wr_en = 1'b1;
                req.pos   = n_rear;
            end else begin
                n_front   = prv(r_front, ring_n);
                req.wr_en = 1'b1;
                req.pos   = n_front;
            end
        end else if (empty) begin
            o_status = ST_UNDERFLOW;
        end else begin
            o_pop_ok  = 1'b1;
            req.rd_en = 1'b1;
            if (r_front == r_rear) begin
                req.pos = r_front;
                n_front = '0;
                n_rear  = '0;
            end else if (i_command == CMD_POP_FRONT) begin
                req.pos = r_front;
                n_front = nxt(r_front, ring_n);
            end else begin
                req.pos = r_rear;
                n_rear  = prv(r_rear, ring_n);
            end
        end
    end

    always_comb begin
        o_req       = req;
        o_req.wr_en = req.wr_en && i_fire;
        o_req.rd_en = req.rd_en && i_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_rear     <= '0;
            r_capacity <= CAPACITY_RESET;
            r_mode     <= MODE_IN_RESTRICT;
        end else begin
            if (i_fire) begin
                r_front <= n_front;
                r_rear  <= n_rear;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CAPACITY: begin
                        r_capacity <= i_cfg_data;
                        r_front    <= '0;
                        r_rear     <= '0;
                    end
                    CFG_MODE: begin
                        r_mode <= i_cfg_data[0];
                    end
                    default: begin
                        r_mode <= r_mode;
                    end
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/restricted_ring_deque_unit.sv =====
// ----------------------------------------------------------------------------
// restricted_ring_deque_unit
// double-ended queue in a ring of slots with input or output restriction
// ----------------------------------------------------------------------------
// channels: i_cmd takes one command item (push rear, pop front, pop rear,
//   push front) with a push value; o_res returns exactly one result item per
//   command with a status and the popped value; i_cfg, always ready, writes
//   capacity (index 0, clears the deque) and restrict mode (index 1); the user
//   writes it only while no command is in flight; the block does not check
// result path: the slot memory read and the pending status are registered
//   when a command is accepted; the output register loads from them once it
//   is empty or o_res.ready frees it
// throughput: one command per cycle unless o_res stalls; the single slot
//   memory port does a push write or a pop read; indices update at accept
// reset: synchronous, indices cleared (deque empty), capacity 16, input
//   restricted mode; slot contents are left as they are
// stall: a result waiting in the output register holds; one more command
//   is accepted into the read stage, after which i_cmd.ready drops until
//   o_res.ready frees the output register
// ----------------------------------------------------------------------------
`include "restricted_ring_deque_unit_defines.svh"

module restricted_ring_deque_unit #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rrd_cmd_if.sink   i_cmd,
    rrd_cfg_if.sink   i_cfg,
    rrd_res_if.source o_res
);
    import rrd_pkg::*;

    logic              fire;
    logic              pend_move;
    t_mem_req          mem_req;
    logic [STAT_W-1:0] dec_status;
    logic              dec_pop_ok;
    logic [VAL_W-1:0]  rdata;

    logic              r_pend_valid;
    logic [STAT_W-1:0] r_pend_status;
    logic              r_pend_pop_ok;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [VAL_W-1:0]  r_out_value;

    assign fire        = i_cmd.valid && i_cmd.ready;
    assign pend_move   = r_pend_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_pend_valid || pend_move;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.popped_value = r_out_value;

    rrd_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_command    (i_cmd.command),
        .i_push_value (i_cmd.push_value),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_req        (mem_req),
        .o_status     (dec_status),
        .o_pop_ok     (dec_pop_ok)
    );

    rrd_slot_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (fire) begin
                r_pend_valid <= 1'b1;
            end else if (pend_move) begin
                r_pend_valid <= 1'b0;
            end
            if (pend_move) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pend_status <= dec_status;
            r_pend_pop_ok <= dec_pop_ok;
        end
        if (pend_move) begin
            r_out_status <= r_pend_status;
            r_out_value  <= r_pend_pop_ok ? rdata : '0;
        end
    end

    `RRD_ASSERT_NEXT(a_pend_reaches_out, r_pend_valid && !r_out_valid, r_out_valid, "pending item not moved to output")
    `RRD_ASSERT_IMPL(a_no_accept_when_full, r_pend_valid && r_out_valid && !o_res.ready, !i_cmd.ready, "command accepted with both stages held")
    `RRD_ASSERT_IMPL(a_value_zero_on_error, r_out_valid && r_out_status != ST_OK, r_out_value == '0, "nonzero popped value on failed command")

endmodule
